// ===== sv/shuffled_lcg_random_source_macros.svh =====
// Assertion macros for the controller of the shuffled LCG random source RTL.
// Needs a clock named clk and a synchronous reset named rst in the using scope.
`ifndef SHUFFLED_LCG_RANDOM_SOURCE_MACROS_SVH
`define SHUFFLED_LCG_RANDOM_SOURCE_MACROS_SVH

// same-cycle implication
`define SLRS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SLRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// plain invariant
`define SLRS_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error(msg);

`endif

// ===== sv/slrs_pkg.sv =====
// Package for the shuffled LCG random source: sizes, constants, mode codes,
// and the command/status structs between controller and datapath. No dependencies.
package slrs_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int WORD_W      = 31;
  localparam int WARMUP      = 8;
  localparam int FILL_STEPS  = TABLE_DEPTH + WARMUP;
  localparam int CNT_W       = $clog2(FILL_STEPS);

  localparam int MUL_W = 15;
  localparam logic [MUL_W-1:0]  LCG_MUL = 15'd16807;
  localparam int PROD_W = WORD_W + MUL_W;
  localparam logic [WORD_W-1:0] LCG_MOD = 31'h7FFF_FFFF;

  // slot = shuffle output / SLOT_DIV, found by comparing against constant multiples
  localparam longint unsigned SLOT_DIV =
    64'd1 + ((64'(LCG_MOD) - 64'd1) / 64'(TABLE_DEPTH));
  localparam int SLOT_QW = $clog2(TABLE_DEPTH + 1);

  localparam int DIV_CNT_W = $clog2(WORD_W);

  // a draw n is kept when n - (n mod span) + span <= 2^31
  localparam logic [32:0] ACCEPT_LIMIT = 33'h0_8000_0000;

  localparam logic [1:0] MODE_SEED  = 2'd0;
  localparam logic [1:0] MODE_RAW   = 2'd1;
  localparam logic [1:0] MODE_RANGE = 2'd2;

  typedef struct packed {
    logic load;       // capture input transaction
    logic seed;       // reseed
    logic fill_init;  // start table refill
    logic lcg_load;   // working word from generator word
    logic mul;        // multiply stage of a generator step
    logic fill_red;   // reduce and store during refill
    logic adv_red;    // reduce the draw step, register the slot
    logic mem_read;   // read table at slot
    logic swap;       // take table entry, write new word back
    logic div_start;  // start span remainder
    logic res_lo;     // result is range_low
    logic res_range;  // result is low plus remainder
    logic out_load;   // move result to output register
  } slrs_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       span_bad;
    logic       need_fill;
    logic       fill_last;
    logic       div_done;
    logic       accept_ok;
  } slrs_stat_t;

endpackage

// ===== sv/shuffled_lcg_random_source.sv =====
// Shuffled minimal-standard random source, top level: controller plus datapath.
// A raw draw runs decode, draw, multiply, fold and slot lookup, read, swap and output; the
// 32-entry shuffle table is refilled first when needed (40 generator steps). A range draw
// adds the span remainder and draws again on each rejection; a bad span answers range_low.
// One transaction in flight; reseed returns to idle. The next input is taken in the cycle
// after a result is loaded, while it waits. Reset clears generator word and shuffle output.
module shuffled_lcg_random_source (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         mode,
  input  logic signed [31:0] seed_value,
  input  logic signed [31:0] range_low,
  input  logic signed [31:0] range_high,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] random_value
);
  import slrs_pkg::*;

  // Command and status buses between the sequencer and the datapath.
  slrs_cmd_t  cmd;
  slrs_stat_t st;

  // Controller: one state per datapath operation. A draw runs
  //   DRAW -> (refill loop) -> multiply -> fold and slot lookup -> read -> swap
  // and a range transaction loops back to DRAW when the remainder check rejects.
  slrs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .st        (st)
  );

  // Datapath: generator step is a 31x15 multiply, registered, then a fold
  // modulo 2^31-1. The table is a single-port-write, registered-read memory.
  // Span remainder comes from a bit-serial divider inside the datapath.
  slrs_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .mode         (mode),
    .seed_value   (seed_value),
    .range_low    (range_low),
    .range_high   (range_high),
    .random_value (random_value),
    .cmd          (cmd),
    .st           (st)
  );

endmodule

// ===== sv/slrs_div.sv =====
// Bit-serial restoring divider giving the remainder of a 31-bit draw by the span.
// Depends on slrs_pkg.
module slrs_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [30:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] remainder
);
  import slrs_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [WORD_W-1:0]    dvd;
  logic [31:0]          trial;
  logic                 ge;

  // remainder stays below divisor <= 2^31, so its top bit is free
  assign trial = {remainder[30:0], dvd[WORD_W-1]};
  assign ge    = trial >= divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      dvd       <= dividend;
      cnt       <= DIV_CNT_W'(WORD_W - 1);
    end else if (busy) begin
      remainder <= ge ? (trial - divisor) : trial;
      dvd       <= {dvd[WORD_W-2:0], 1'b0};
      cnt       <= cnt - 1'b1;
    end
  end

endmodule

// ===== sv/slrs_dp.sv =====
// Datapath: generator step (multiply, fold mod 2^31-1), shuffle table memory,
// slot lookup, span check and result/output registers. Depends on slrs_pkg, slrs_div.
module slrs_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [1:0]             mode,
  input  logic signed [31:0]     seed_value,
  input  logic signed [31:0]     range_low,
  input  logic signed [31:0]     range_high,
  output logic signed [31:0]     random_value,
  input  slrs_pkg::slrs_cmd_t    cmd,
  output slrs_pkg::slrs_stat_t   st
);
  import slrs_pkg::*;

  // captured transaction
  logic [1:0]  mode_r;
  logic [31:0] seed_r;
  logic [31:0] lo_r;
  logic [31:0] hi_r;

  // generator state
  logic [31:0]       lcg;
  logic [WORD_W-1:0] sout;
  logic [WORD_W-1:0] s_work;
  logic [PROD_W-1:0] prod;
  logic [CNT_W-1:0]  cnt;

  // slot lookup
  logic [SLOT_QW-1:0] slot_q;
  logic [ADDR_W-1:0]  slot_addr;

  // table
  logic [WORD_W-1:0] shuf_mem [TABLE_DEPTH];
  logic [WORD_W-1:0] rd_data;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [WORD_W-1:0] wr_data;

  logic [31:0]       result;
  logic [31:0]       fsum;
  logic [31:0]       fsub;
  logic [WORD_W-1:0] fold;
  logic [31:0]       neg;
  logic [WORD_W-1:0] fill_start;
  logic [31:0]       span_m1;
  logic [31:0]       span;
  logic [32:0]       chk;
  logic              div_done;
  logic [31:0]       div_rem;

  // x mod (2^31-1): add high part onto low part, subtract once
  assign fsum = {1'b0, prod[WORD_W-1:0]} + 32'(prod[PROD_W-1:WORD_W]);
  assign fsub = fsum - 32'(LCG_MOD);
  assign fold = (fsum >= 32'(LCG_MOD)) ? fsub[WORD_W-1:0] : fsum[WORD_W-1:0];

  assign neg        = 32'd0 - lcg;
  assign fill_start = (neg[31] || neg == '0) ? WORD_W'(1) : neg[WORD_W-1:0];

  assign span_m1 = hi_r - lo_r;
  assign span    = span_m1 + 32'd1;

  // quotient by SLOT_DIV: thresholds k*SLOT_DIV are constants rising with k
  always_comb begin
    slot_q = '0;
    for (int k = 1; k <= TABLE_DEPTH; k++) begin
      if ({1'b0, sout} >= 32'(longint'(k) * SLOT_DIV)) slot_q = SLOT_QW'(k);
    end
  end

  assign chk = {2'b00, sout} - {1'b0, div_rem} + {1'b0, span};

  assign wr_en   = (cmd.fill_red && cnt < CNT_W'(TABLE_DEPTH)) || cmd.swap;
  assign wr_addr = cmd.swap ? slot_addr : cnt[ADDR_W-1:0];
  assign wr_data = cmd.swap ? s_work : fold;

  assign st.mode      = mode_r;
  assign st.span_bad  = span_m1[31] || span_m1 == '0;
  assign st.need_fill = lcg[31] || lcg == '0 || sout == '0;
  assign st.fill_last = cnt == '0;
  assign st.div_done  = div_done;
  assign st.accept_ok = chk <= ACCEPT_LIMIT;

  slrs_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (rd_data),
    .divisor   (span),
    .done      (div_done),
    .remainder (div_rem)
  );

  // architectural state with reset values
  always_ff @(posedge clk) begin
    if (rst) begin
      lcg  <= '0;
      sout <= '0;
    end else begin
      if (cmd.seed) lcg <= seed_r[31] ? seed_r : (32'd0 - seed_r);
      if (cmd.adv_red) lcg <= {1'b0, fold};
      if (cmd.fill_red && cnt == '0) sout <= fold;
      if (cmd.seed) sout <= '0;
      if (cmd.swap) sout <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= mode;
      seed_r <= seed_value;
      lo_r   <= range_low;
      hi_r   <= range_high;
    end
    if (cmd.fill_init) begin
      s_work <= fill_start;
      cnt    <= CNT_W'(FILL_STEPS - 1);
    end
    if (cmd.lcg_load) s_work <= lcg[WORD_W-1:0];
    if (cmd.mul) prod <= s_work * LCG_MUL;
    if (cmd.fill_red) begin
      s_work <= fold;
      cnt    <= cnt - 1'b1;
    end
    if (cmd.adv_red) begin
      s_work    <= fold;
      slot_addr <= (slot_q >= SLOT_QW'(TABLE_DEPTH)) ? ADDR_W'(TABLE_DEPTH - 1)
                                                      : slot_q[ADDR_W-1:0];
    end
    if (cmd.swap) result <= {1'b0, rd_data};
    if (cmd.res_lo) result <= lo_r;
    if (cmd.res_range) result <= lo_r + div_rem;
    if (cmd.out_load) random_value <= result;
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_read) rd_data <= shuf_mem[slot_addr];
    if (wr_en) shuf_mem[wr_addr] <= wr_data;
  end

endmodule

// ===== sv/slrs_ctrl.sv =====
// Controller state machine: sequences reseed, refill, draw, slot lookup,
// span remainder and output handshake. Depends on slrs_pkg and the macros header.
`include "shuffled_lcg_random_source_macros.svh"

module slrs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output slrs_pkg::slrs_cmd_t  cmd,
  input  slrs_pkg::slrs_stat_t st
);
  import slrs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_DRAW, S_FILL_MUL, S_FILL_RED, S_ADV_MUL, S_ADV_RED,
    S_READ, S_SWAP, S_DIV, S_OUT
  } state_t;

  state_t state, state_next;
  logic [4:0] dp_ops;

  assign in_ready = state == S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (st.mode)
          MODE_SEED: begin
            cmd.seed   = 1'b1;
            state_next = S_IDLE;
          end
          MODE_RAW: state_next = S_DRAW;
          MODE_RANGE: begin
            if (st.span_bad) begin
              cmd.res_lo = 1'b1;
              state_next = S_OUT;
            end else begin
              state_next = S_DRAW;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_DRAW: begin
        if (st.need_fill) begin
          cmd.fill_init = 1'b1;
          state_next    = S_FILL_MUL;
        end else begin
          cmd.lcg_load = 1'b1;
          state_next   = S_ADV_MUL;
        end
      end
      S_FILL_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_FILL_RED;
      end
      S_FILL_RED: begin
        cmd.fill_red = 1'b1;
        state_next   = st.fill_last ? S_ADV_MUL : S_FILL_MUL;
      end
      S_ADV_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ADV_RED;
      end
      S_ADV_RED: begin
        cmd.adv_red = 1'b1;
        state_next  = S_READ;
      end
      S_READ: begin
        cmd.mem_read = 1'b1;
        state_next   = S_SWAP;
      end
      S_SWAP: begin
        cmd.swap = 1'b1;
        if (st.mode == MODE_RANGE) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          state_next = S_OUT;
        end
      end
      S_DIV: begin
        if (st.div_done) begin
          if (st.accept_ok) begin
            cmd.res_range = 1'b1;
            state_next    = S_OUT;
          end else begin
            state_next = S_DRAW;
          end
        end
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign dp_ops = {cmd.mul, cmd.fill_red, cmd.adv_red, cmd.mem_read, cmd.swap};

  `SLRS_ASSERT_ALWAYS(a_one_op, $onehot0(dp_ops), "two datapath operations in one cycle")
  `SLRS_ASSERT_IMPL(a_no_overwrite, cmd.out_load, !out_valid || out_ready, "output overwritten")
  `SLRS_ASSERT_IMPL(a_div_done_wait, st.div_done, state == S_DIV, "remainder outside wait")
  `SLRS_ASSERT_NEXT(a_div_not_instant, cmd.div_start, !st.div_done, "remainder too early")

endmodule
